// ===== design/pdbm_pkg.sv =====
// Shared constants, types and the log-fraction table of the peak-to-peak dB meter.
`timescale 1ns / 1ps
package pdbm_pkg;

   // Sample and table geometry.
   localparam int SAMPLE_BITS    = 10;
   localparam int SAMPLE_IN_BITS = SAMPLE_BITS + 1;
   localparam int LOG_TABLE_BITS = 6;
   localparam int LOG_TABLE_SIZE = 1 << LOG_TABLE_BITS;
   localparam int PTP_BITS       = 10;
   localparam int LIMIT_BITS     = 10;
   localparam int DB_BITS        = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;

   // Leading-one position, log2 in Q16 and the scaled product.
   localparam int POS_BITS      = $clog2(SAMPLE_BITS);
   localparam int FRAC_BITS     = 16;
   localparam int L2_BITS       = POS_BITS + FRAC_BITS;
   localparam int DBO_BITS      = 19;
   localparam logic [DBO_BITS-1:0] DB_PER_OCTAVE_Q16 = DBO_BITS'(394566);
   localparam int PROD_BITS     = L2_BITS + DBO_BITS;
   localparam int ROUND_SHIFT   = 24;
   localparam int LVL_RAW_BITS  = PROD_BITS + 1 - ROUND_SHIFT;
   localparam int LVL_SUM_BITS  = ((LVL_RAW_BITS > DB_BITS) ? LVL_RAW_BITS : DB_BITS) + 2;

   // Register reset values.
   localparam logic [LIMIT_BITS-1:0]     VALID_LIMIT_RESET = LIMIT_BITS'(1023);
   localparam logic signed [DB_BITS-1:0] DB_OFFSET_RESET   = DB_BITS'(1066);

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_VALID_LIMIT = 1'b0,
      CSR_DB_OFFSET   = 1'b1
   } csr_index_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_VALID     = 2'd0,
      STATUS_ZERO_SPAN = 2'd1,
      STATUS_EMPTY     = 2'd2
   } level_status_type;

   // Window extremes captured when a window closes.
   typedef struct packed {
      logic                      valid;
      logic                      seen;
      logic [SAMPLE_BITS-1:0]    win_max;
      logic [SAMPLE_IN_BITS-1:0] win_min;
   } close_type;

   // Span and unscaled level product, one stage later.
   typedef struct packed {
      logic                   valid;
      level_status_type       status;
      logic [SAMPLE_BITS-1:0] span;
      logic [PROD_BITS-1:0]   prod;
   } product_type;

   typedef logic [FRAC_BITS-1:0] log_table_type [LOG_TABLE_SIZE];

   // log2(1 + i/2^LOG_TABLE_BITS) in Q16, built bit by bit by repeated squaring of a
   // Q30 mantissa. Evaluated at elaboration only.
   function automatic log_table_type build_log_table();
      log_table_type        tbl;
      logic [63:0]          m;
      logic [FRAC_BITS-1:0] r;
      for (int i = 0; i < LOG_TABLE_SIZE; i++) begin
         m = 64'(LOG_TABLE_SIZE + i) << (30 - LOG_TABLE_BITS);
         r = '0;
         for (int k = 0; k < FRAC_BITS; k++) begin
            m = (m * m) >> 30;
            r = r << 1;
            if (m >= (64'd1 << 31)) begin
               r[0] = 1'b1;
               m    = m >> 1;
            end
         end
         tbl[i] = r;
      end
      return tbl;
   endfunction

   localparam log_table_type LOG_TABLE = build_log_table();

endpackage

// ===== design/pdbm_window.sv =====
// Window tracker: running maximum and minimum, captured when a window closes.
`timescale 1ns / 1ps
module pdbm_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              req_valid,
   input  logic [pdbm_pkg::SAMPLE_IN_BITS-1:0] req_sample,
   input  logic                              req_last_in_window,
   input  logic [pdbm_pkg::LIMIT_BITS-1:0]   valid_limit,
   output pdbm_pkg::close_type               close_out
);
   import pdbm_pkg::*;

   localparam logic [SAMPLE_IN_BITS-1:0] MIN_RESET = SAMPLE_IN_BITS'(1) << SAMPLE_BITS;

   logic                      accept;
   logic                      sample_ok;
   logic [SAMPLE_BITS-1:0]    sample_low;
   logic [SAMPLE_BITS-1:0]    max_ff, max_in;
   logic [SAMPLE_IN_BITS-1:0] min_ff, min_in;
   logic                      seen_ff, seen_in;
   close_type                 close_ff, close_in;

   // A sample counts when it is within the limit and within the converter range.
   always_comb begin
      accept     = req_valid && advance;
      sample_low = req_sample[SAMPLE_BITS-1:0];
      sample_ok  = (req_sample[SAMPLE_BITS] == 1'b0) &&
                   (32'(req_sample) <= 32'(valid_limit));
   end

   // Updated extremes, including the beat being accepted.
   always_comb begin
      max_in  = max_ff;
      min_in  = min_ff;
      seen_in = seen_ff;
      if (accept && sample_ok) begin
         if (sample_low > max_ff) begin
            max_in = sample_low;
         end
         if (SAMPLE_IN_BITS'(sample_low) < min_ff) begin
            min_in = SAMPLE_IN_BITS'(sample_low);
         end
         seen_in = 1'b1;
      end
   end

   // Capture the closing extremes for the log stage.
   always_comb begin
      close_in = close_ff;
      if (advance) begin
         close_in.valid   = accept && req_last_in_window;
         close_in.seen    = seen_in;
         close_in.win_max = max_in;
         close_in.win_min = min_in;
      end
   end

   // Tracking state returns to its cleared values once a window closes.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= '0;
         min_ff  <= MIN_RESET;
         seen_ff <= 1'b0;
      end else if (accept && req_last_in_window) begin
         max_ff  <= '0;
         min_ff  <= MIN_RESET;
         seen_ff <= 1'b0;
      end else begin
         max_ff  <= max_in;
         min_ff  <= min_in;
         seen_ff <= seen_in;
      end
   end

   // Capture register; only the valid flag needs a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         close_ff.valid <= 1'b0;
      end else begin
         close_ff.valid <= close_in.valid;
      end
      close_ff.seen    <= close_in.seen;
      close_ff.win_max <= close_in.win_max;
      close_ff.win_min <= close_in.win_min;
   end

   assign close_out = close_ff;

endmodule

// ===== design/pdbm_log.sv =====
// Log stage: span, leading-one position, fraction lookup and the dB-scale product.
`timescale 1ns / 1ps
module pdbm_log (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  pdbm_pkg::close_type   close_in,
   output pdbm_pkg::product_type product_out
);
   import pdbm_pkg::*;

   logic [SAMPLE_BITS-1:0]                span;
   logic [POS_BITS-1:0]                   pos;
   logic [SAMPLE_BITS+LOG_TABLE_BITS-1:0] aligned;
   logic [LOG_TABLE_BITS-1:0]             idx;
   logic [L2_BITS-1:0]                    log2_q16;
   level_status_type                      status;
   product_type                           prod_ff, prod_in;

   // Span and status of the closed window.
   always_comb begin
      span = close_in.win_max - close_in.win_min[SAMPLE_BITS-1:0];
      if (!close_in.seen) begin
         status = STATUS_EMPTY;
         span   = '0;
      end else if (span == '0) begin
         status = STATUS_ZERO_SPAN;
      end else begin
         status = STATUS_VALID;
      end
   end

   // Leading-one position; the highest set bit wins.
   always_comb begin
      pos = '0;
      for (int i = 0; i < SAMPLE_BITS; i++) begin
         if (span[i]) begin
            pos = POS_BITS'(i);
         end
      end
   end

   // The table index is the bits just below the leading one, zero padded at the bottom.
   always_comb begin
      aligned  = {span, {LOG_TABLE_BITS{1'b0}}} >> pos;
      idx      = aligned[LOG_TABLE_BITS-1:0];
      log2_q16 = {pos, LOG_TABLE[idx]};
   end

   // Scale by 20*log10(2) and register the product.
   always_comb begin
      prod_in = prod_ff;
      if (advance) begin
         prod_in.valid  = close_in.valid;
         prod_in.status = status;
         prod_in.span   = span;
         prod_in.prod   = PROD_BITS'(log2_q16) * PROD_BITS'(DB_PER_OCTAVE_Q16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff.valid <= 1'b0;
      end else begin
         prod_ff.valid <= prod_in.valid;
      end
      prod_ff.status <= prod_in.status;
      prod_ff.span   <= prod_in.span;
      prod_ff.prod   <= prod_in.prod;
   end

   assign product_out = prod_ff;

endmodule

// ===== design/pdbm_level.sv =====
// Level stage: rounding, offset, saturation and the result register.
`timescale 1ns / 1ps
module pdbm_level (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  pdbm_pkg::product_type               product_in,
   input  logic signed [pdbm_pkg::DB_BITS-1:0] db_offset,
   output logic                                rsp_valid,
   output logic [pdbm_pkg::PTP_BITS-1:0]       rsp_peak_to_peak,
   output logic signed [pdbm_pkg::DB_BITS-1:0] rsp_level_db_q8,
   output pdbm_pkg::level_status_type          rsp_level_status
);
   import pdbm_pkg::*;

   localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS + 1)'(1) << (ROUND_SHIFT - 1);
   localparam logic signed [LVL_SUM_BITS-1:0] LVL_MAX = LVL_SUM_BITS'(32767);
   localparam logic signed [LVL_SUM_BITS-1:0] LVL_MIN = -(LVL_SUM_BITS'(32768));
   localparam logic signed [DB_BITS-1:0]      DB_FLOOR = DB_BITS'(16'h8000);

   logic [PROD_BITS:0]               rounded_sum;
   logic [LVL_RAW_BITS-1:0]          rounded;
   logic signed [LVL_SUM_BITS-1:0]   level_sum;
   logic signed [DB_BITS-1:0]        level;
   logic                             valid_ff, valid_in;
   logic [PTP_BITS-1:0]              ptp_ff, ptp_in;
   logic signed [DB_BITS-1:0]        level_ff, level_in;
   level_status_type                 status_ff, status_in;

   // Round half up to Q8, add the offset and saturate; flagged windows read the floor.
   always_comb begin
      rounded_sum = (PROD_BITS + 1)'(product_in.prod) + ROUND_HALF;
      rounded     = rounded_sum[PROD_BITS:ROUND_SHIFT];
      level_sum   = $signed(LVL_SUM_BITS'(rounded)) + LVL_SUM_BITS'(db_offset);
      if (product_in.status != STATUS_VALID) begin
         level = DB_FLOOR;
      end else if (level_sum > LVL_MAX) begin
         level = LVL_MAX[DB_BITS-1:0];
      end else if (level_sum < LVL_MIN) begin
         level = LVL_MIN[DB_BITS-1:0];
      end else begin
         level = level_sum[DB_BITS-1:0];
      end
   end

   // Result register loads whenever the pipeline moves.
   always_comb begin
      valid_in  = valid_ff;
      ptp_in    = ptp_ff;
      level_in  = level_ff;
      status_in = status_ff;
      if (advance) begin
         valid_in  = product_in.valid;
         ptp_in    = product_in.span[PTP_BITS-1:0];
         level_in  = level;
         status_in = product_in.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      ptp_ff    <= ptp_in;
      level_ff  <= level_in;
      status_ff <= status_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_peak_to_peak = ptp_ff;
   assign rsp_level_db_q8  = level_ff;
   assign rsp_level_status = status_ff;

endmodule

// ===== design/window_peak_to_peak_db_meter.sv =====
// Top level of the windowed peak-to-peak sound level meter.
`timescale 1ns / 1ps
// The meter takes one sample beat per cycle and tracks the maximum and minimum of the
// accepted samples of the current window; samples above valid_limit, or flagged as
// spurious, are ignored, but their window flag still closes the window. The beat that
// closes a window yields one result beat from the last stage: the peak-to-peak span and
// 20*log10(span) plus db_offset_q8 in signed Q8 dB, saturating, with a status code for a
// zero span or an empty window. The three stages (window capture, log and multiply,
// rounding and offset) move together, so a stalled result holds the whole pipeline and
// the input is stalled only in those cycles. Configuration writes are always ready.
module window_peak_to_peak_db_meter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [pdbm_pkg::SAMPLE_IN_BITS-1:0]  req_sample,
   input  logic                                 req_last_in_window,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [pdbm_pkg::PTP_BITS-1:0]        rsp_peak_to_peak,
   output logic signed [pdbm_pkg::DB_BITS-1:0]  rsp_level_db_q8,
   output pdbm_pkg::level_status_type           rsp_level_status,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pdbm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pdbm_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import pdbm_pkg::*;

   logic                         advance;
   logic [LIMIT_BITS-1:0]        valid_limit_ff;
   logic signed [DB_BITS-1:0]    db_offset_ff;
   close_type                    close_bus;
   product_type                  product_bus;

   // The pipeline moves unless a result waits on a stalled receiver.
   always_comb begin
      advance   = !(rsp_valid && rsp_stall);
      req_stall = !advance;
      csr_ready = 1'b1;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_limit_ff <= VALID_LIMIT_RESET;
         db_offset_ff   <= DB_OFFSET_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VALID_LIMIT: valid_limit_ff <= csr_wdata[LIMIT_BITS-1:0];
            CSR_DB_OFFSET:   db_offset_ff   <= $signed(csr_wdata[DB_BITS-1:0]);
         endcase
      end
   end

   pdbm_window u_window (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .req_valid          (req_valid),
      .req_sample         (req_sample),
      .req_last_in_window (req_last_in_window),
      .valid_limit        (valid_limit_ff),
      .close_out          (close_bus)
   );

   pdbm_log u_log (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .close_in    (close_bus),
      .product_out (product_bus)
   );

   pdbm_level u_level (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .product_in       (product_bus),
      .db_offset        (db_offset_ff),
      .rsp_valid        (rsp_valid),
      .rsp_peak_to_peak (rsp_peak_to_peak),
      .rsp_level_db_q8  (rsp_level_db_q8),
      .rsp_level_status (rsp_level_status)
   );

endmodule

// ===== design/pdbm_checker.sv =====
// Port-level checker for the peak-to-peak dB meter, bound to the top level.
`timescale 1ns / 1ps
module pdbm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [pdbm_pkg::PTP_BITS-1:0]       rsp_peak_to_peak,
   input logic signed [pdbm_pkg::DB_BITS-1:0] rsp_level_db_q8,
   input pdbm_pkg::level_status_type          rsp_level_status
);
   import pdbm_pkg::*;

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_peak_to_peak) &&
         $stable(rsp_level_db_q8) && $stable(rsp_level_status))
      else $error("stalled result beat changed");

   // The input is held back only while a result waits on a stalled receiver.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

   // Flagged windows carry no span and the floor level.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_level_status == STATUS_EMPTY ||
                    rsp_level_status == STATUS_ZERO_SPAN) |->
         rsp_peak_to_peak == '0 && rsp_level_db_q8 == DB_BITS'(16'h8000))
      else $error("flagged window with span or level");

   // A valid level always comes from a non-zero span.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_level_status == STATUS_VALID |-> rsp_peak_to_peak != '0)
      else $error("valid level with zero span");

endmodule

bind window_peak_to_peak_db_meter pdbm_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_peak_to_peak (rsp_peak_to_peak),
   .rsp_level_db_q8  (rsp_level_db_q8),
   .rsp_level_status (rsp_level_status)
);
